[sv/tvsd_pkg.sv]
package tvsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int SUB_W    = 5;
    localparam int CNT_W    = 4;
    localparam int VALUE_W  = 64;
    localparam int STRLEN_W = 32;
    localparam int TUSER_W  = 8;
    localparam int QDEPTH   = 2;

    localparam logic [CNT_W-1:0] PTR_BYTES_RESET = 4'd8;
    localparam logic [CNT_W-1:0] PTR_BYTES_NARROW = 4'd4;
    localparam logic [CNT_W-1:0] PTR_BYTES_WIDE = 4'd8;
    localparam logic [CNT_W-1:0] REAL_BYTES = 4'd8;
    localparam logic [SUB_W-1:0] SUB_COUNT_ESCAPE = 5'd31;
    localparam logic [SUB_W-1:0] SUB_NUM_REAL = 5'd5;
    localparam logic [SUB_W-1:0] SUB_INT32 = 5'd2;
    localparam logic [SUB_W-1:0] SUB_INT16 = 5'd3;
    localparam logic [SUB_W-1:0] SUB_INT8 = 5'd4;

    typedef enum logic [2:0] {
        TAG_NIL    = 3'd0,
        TAG_BOOL   = 3'd1,
        TAG_NUMBER = 3'd2,
        TAG_PTR    = 3'd3,
        TAG_SSTR   = 3'd4,
        TAG_LSTR   = 3'd5,
        TAG_TABLE  = 3'd6,
        TAG_SKIP   = 3'd7
    } tag_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CNTTAG,
        PH_INT,
        PH_REAL,
        PH_PTR,
        PH_LEN,
        PH_STR
    } phase_t;

    typedef enum logic [3:0] {
        TK_NIL    = 4'd0,
        TK_BOOL   = 4'd1,
        TK_INT    = 4'd2,
        TK_REAL   = 4'd3,
        TK_PTR    = 4'd4,
        TK_SSTART = 4'd5,
        TK_SBYTE  = 4'd6,
        TK_TABLE  = 4'd7,
        TK_ERR    = 4'd8
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNC     = 2'd1,
        ERR_INT_WIDTH = 2'd2,
        ERR_LEN_WIDTH = 2'd3
    } err_code_t;

    // classified input byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        tag_kind_t         kind;
        logic [SUB_W-1:0]  sub;
        logic              sub_zero;
        logic [CNT_W-1:0]  int_need;   // 0 when the subtype is no integer width
    } item_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [VALUE_W-1:0] value;
        logic               str_end;
        err_code_t          err;
    } token_t;

    function automatic logic [CNT_W-1:0] int_width(input logic [SUB_W-1:0] sub);
        logic [CNT_W-1:0] w;
        unique case (sub)
            5'd1:    w = 4'd8;
            5'd2:    w = 4'd4;
            5'd3:    w = 4'd2;
            5'd4:    w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [VALUE_W-1:0] int_value(input logic [SUB_W-1:0] sub,
                                                     input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        unique case (sub)
            SUB_INT32: r = {{32{v[31]}}, v[31:0]};
            SUB_INT16: r = {48'b0, v[15:0]};
            SUB_INT8:  r = {56'b0, v[7:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage

[sv/tvsd_front.sv]
module tvsd_front
(
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    output logic                   push,
    output tvsd_pkg::item_t        push_item,
    input  logic                   q_ready
);
    import tvsd_pkg::*;

    logic [SUB_W-1:0] sub;

    assign sub      = s_tdata[BYTE_W-1:3];
    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    always_comb
    begin
        push_item.data     = s_tdata;
        push_item.last     = s_tlast;
        push_item.kind     = tag_kind_t'(s_tdata[2:0]);
        push_item.sub      = sub;
        push_item.sub_zero = (sub == '0);
        push_item.int_need = int_width(sub);
    end

endmodule

[sv/tvsd_queue.sv]
module tvsd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tvsd_pkg::item_t   push_item,
    output logic              q_ready,
    output logic              pop_valid,
    output tvsd_pkg::item_t   pop_item,
    input  logic              pop
);
    import tvsd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    item_t             mem [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign q_ready   = (count_reg != CNT_QW'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/tvsd_back.sv]
module tvsd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_data,
    input  logic              in_valid,
    input  tvsd_pkg::item_t   in_item,
    output logic              in_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tvsd_pkg::token_t  out_token
);
    import tvsd_pkg::*;

    logic [CNT_W-1:0]    ptr_bytes_reg;
    phase_t              phase_reg, phase_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [CNT_W-1:0]    taken_reg, taken_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [STRLEN_W-1:0] rem_reg, rem_next;
    logic                pend_tbl_reg, pend_tbl_next;
    logic                discard_reg, discard_next;
    logic                out_valid_reg, out_valid_next;
    token_t              tok_reg, tok_next;

    logic                can_take;
    logic                fire;
    logic                err;
    logic [VALUE_W-1:0]  acc_or;
    logic [CNT_W-1:0]    taken_inc;
    logic [STRLEN_W-1:0] rem_dec;
    logic [VALUE_W-1:0]  ival;

    assign can_take  = !out_valid_reg || out_ready;
    assign in_pop    = in_valid && can_take;
    assign fire      = in_pop;
    assign out_valid = out_valid_reg;
    assign out_token = tok_reg;

    assign acc_or    = acc_reg | ({56'b0, in_item.data} << {taken_reg[2:0], 3'b000});
    assign taken_inc = taken_reg + 1'b1;
    assign rem_dec   = rem_reg - 1'b1;
    assign ival      = int_value(sub_reg, acc_or);

    always_comb
    begin
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        need_next      = need_reg;
        taken_next     = taken_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        pend_tbl_next  = pend_tbl_reg;
        discard_next   = discard_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tok_next       = tok_reg;
        err            = 1'b0;

        if (fire)
        begin
            tok_next.kind    = TK_NIL;
            tok_next.value   = '0;
            tok_next.str_end = 1'b0;
            tok_next.err     = ERR_NONE;
            if (discard_reg)
            begin
                if (in_item.last)
                begin
                    phase_next    = PH_IDLE;
                    pend_tbl_next = 1'b0;
                    discard_next  = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        unique case (in_item.kind)
                            TAG_NIL:
                            begin
                                out_valid_next = 1'b1;
                            end
                            TAG_BOOL:
                            begin
                                out_valid_next = 1'b1;
                                tok_next.kind  = TK_BOOL;
                                tok_next.value = {63'b0, !in_item.sub_zero};
                            end
                            TAG_NUMBER:
                            begin
                                taken_next = '0;
                                acc_next   = '0;
                                sub_next   = in_item.sub;
                                priority if (in_item.sub_zero)
                                begin
                                    out_valid_next = 1'b1;
                                    tok_next.kind  = TK_INT;
                                end
                                else if (in_item.sub == SUB_NUM_REAL)
                                begin
                                    phase_next = PH_REAL;
                                    need_next  = REAL_BYTES;
                                end
                                else if (in_item.int_need != '0)
                                begin
                                    phase_next = PH_INT;
                                    need_next  = in_item.int_need;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    tok_next.kind  = TK_ERR;
                                    tok_next.err   = ERR_INT_WIDTH;
                                    err            = 1'b1;
                                end
                            end
                            TAG_PTR:
                            begin
                                phase_next = PH_PTR;
                                sub_next   = in_item.sub;
                                taken_next = '0;
                                acc_next   = '0;
                                need_next  = (ptr_bytes_reg == PTR_BYTES_NARROW) ?
                                             PTR_BYTES_NARROW : PTR_BYTES_WIDE;
                            end
                            TAG_SSTR:
                            begin
                                out_valid_next = 1'b1;
                                tok_next.kind  = TK_SSTART;
                                tok_next.value = {59'b0, in_item.sub};
                                if (!in_item.sub_zero)
                                begin
                                    rem_next   = {27'b0, in_item.sub};
                                    phase_next = PH_STR;
                                end
                            end
                            TAG_LSTR:
                            begin
                                if (in_item.sub == SUB_INT32 || in_item.sub == SUB_INT16 ||
                                    in_item.sub == SUB_INT8)
                                begin
                                    phase_next = PH_LEN;
                                    sub_next   = in_item.sub;
                                    taken_next = '0;
                                    acc_next   = '0;
                                    need_next  = in_item.int_need;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    tok_next.kind  = TK_ERR;
                                    tok_next.err   = ERR_LEN_WIDTH;
                                    err            = 1'b1;
                                end
                            end
                            TAG_TABLE:
                            begin
                                if (in_item.sub == SUB_COUNT_ESCAPE)
                                begin
                                    phase_next    = PH_CNTTAG;
                                    pend_tbl_next = 1'b1;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    tok_next.kind  = TK_TABLE;
                                    tok_next.value = {59'b0, in_item.sub};
                                end
                            end
                            TAG_SKIP:
                            begin
                            end
                        endcase
                    end
                    PH_CNTTAG:
                    begin
                        priority if (in_item.sub_zero)
                        begin
                            out_valid_next = 1'b1;
                            tok_next.kind  = TK_TABLE;
                            phase_next     = PH_IDLE;
                            pend_tbl_next  = 1'b0;
                        end
                        else if (in_item.int_need != '0)
                        begin
                            phase_next = PH_INT;
                            sub_next   = in_item.sub;
                            need_next  = in_item.int_need;
                            taken_next = '0;
                            acc_next   = '0;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            tok_next.kind  = TK_ERR;
                            tok_next.err   = ERR_INT_WIDTH;
                            err            = 1'b1;
                            phase_next     = PH_IDLE;
                            pend_tbl_next  = 1'b0;
                        end
                    end
                    PH_STR:
                    begin
                        rem_next         = rem_dec;
                        out_valid_next   = 1'b1;
                        tok_next.kind    = TK_SBYTE;
                        tok_next.value   = {56'b0, in_item.data};
                        tok_next.str_end = (rem_dec == '0);
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        acc_next   = acc_or;
                        taken_next = taken_inc;
                        if (taken_inc >= need_reg)
                        begin
                            out_valid_next = 1'b1;
                            phase_next     = PH_IDLE;
                            unique case (phase_reg)
                                PH_INT:
                                begin
                                    tok_next.kind  = pend_tbl_reg ? TK_TABLE : TK_INT;
                                    tok_next.value = ival;
                                    pend_tbl_next  = 1'b0;
                                end
                                PH_REAL:
                                begin
                                    tok_next.kind  = TK_REAL;
                                    tok_next.value = acc_or;
                                end
                                PH_PTR:
                                begin
                                    tok_next.kind  = TK_PTR;
                                    tok_next.value = (need_reg == PTR_BYTES_NARROW) ?
                                                     {32'b0, acc_or[31:0]} : acc_or;
                                end
                                default:
                                begin
                                    tok_next.kind  = TK_SSTART;
                                    tok_next.value = {32'b0, ival[31:0]};
                                    if (ival[31:0] != '0)
                                    begin
                                        rem_next   = ival[31:0];
                                        phase_next = PH_STR;
                                    end
                                end
                            endcase
                        end
                    end
                endcase

                if (in_item.last)
                begin
                    if (phase_next != PH_IDLE)
                    begin
                        out_valid_next   = 1'b1;
                        tok_next.kind    = TK_ERR;
                        tok_next.value   = '0;
                        tok_next.str_end = 1'b0;
                        tok_next.err     = ERR_TRUNC;
                    end
                    phase_next    = PH_IDLE;
                    pend_tbl_next = 1'b0;
                    discard_next  = 1'b0;
                end
                else if (err)
                begin
                    discard_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_bytes_reg <= PTR_BYTES_RESET;
            phase_reg     <= PH_IDLE;
            pend_tbl_reg  <= 1'b0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ptr_bytes_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            pend_tbl_reg  <= pend_tbl_next;
            discard_reg   <= discard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg   <= sub_next;
        need_reg  <= need_next;
        taken_reg <= taken_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        tok_reg   <= tok_next;
    end

endmodule

[sv/tagged_value_stream_decoder_unit.sv]
// Tagged value stream decoder. Bytes of a serialized buffer enter on s_axis
// (tlast on the final byte) and come out as tokens on m_axis, at most one
// token per byte. The front classifies each byte into its tag kind and
// subtype and pushes it into a two-entry queue; the back pops one byte per
// cycle (the sustained rate) unless m_axis back-pressure stalls it, runs the
// tag/payload state machine and holds the token in an output register; a byte's
// token is registered after the byte passes the queue. Write pointer_bytes
// (4 or 8) through the cfg channel only while no buffer is in flight.
module tagged_value_stream_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,        // pointer_bytes
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,    // data_byte
    input  logic               s_axis_tlast,    // last_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic signed [63:0] m_axis_tdata,    // token_value
    output logic               m_axis_tlast,    // string_end
    output logic [7:0]         m_axis_tuser     // [3:0] token_kind, [5:4] error_code
);
    import tvsd_pkg::*;

    logic   push;
    logic   q_ready;
    item_t  push_item;
    logic   pop_valid;
    logic   pop;
    item_t  pop_item;
    token_t token;

    assign cfg_ready = 1'b1;

    tvsd_front u_front
    (
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tlast   (s_axis_tlast),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    tvsd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop)
    );

    tvsd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (pop_valid),
        .in_item   (pop_item),
        .in_pop    (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_token (token)
    );

    assign m_axis_tdata = token.value;
    assign m_axis_tlast = token.str_end;
    assign m_axis_tuser = {2'b00, token.err, token.kind};

endmodule

[bench/tb_tagged_value_stream_decoder_unit.sv]
`timescale 1ns / 100ps

module tb_tagged_value_stream_decoder_unit;

    import tvsd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [7:0]  m_axis_tuser;

    tagged_value_stream_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // decoder shadow state
    logic [3:0]  ptr_cfg;
    phase_t      dec_phase;
    logic [4:0]  dec_sub;
    logic [3:0]  dec_need;
    logic [3:0]  dec_taken;
    logic [63:0] dec_acc;
    logic [31:0] dec_str_left;
    logic        dec_cnt_pending;
    logic        dec_discard;

    token_t      tokens_due[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches;
    int          items_sent;
    int          sink_hold;
    logic        idle_on;
    logic [3:0]  ptr_setting;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int int_bytes(input logic [4:0] s);
        case (s)
            5'd1:    return 8;
            5'd2:    return 4;
            5'd3:    return 2;
            5'd4:    return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] sized_int(input logic [4:0] s, input logic [63:0] v);
        if (s == SUB_INT32)
            return v[31] ? {32'hFFFF_FFFF, v[31:0]} : {32'd0, v[31:0]};
        if (s == SUB_INT16)
            return {48'd0, v[15:0]};
        if (s == SUB_INT8)
            return {56'd0, v[7:0]};
        return v;
    endfunction

    function automatic token_t tok(input tok_kind_t k, input logic [63:0] v,
                                   input logic e, input err_code_t c);
        token_t t;
        t.kind = k;
        t.value = v;
        t.str_end = e;
        t.err = c;
        return t;
    endfunction

    function automatic logic [7:0] mk_tag(input logic [4:0] s, input logic [2:0] k);
        return {s, k};
    endfunction

    task automatic clear_parse();
        dec_phase = PH_IDLE;
        dec_sub = '0;
        dec_need = '0;
        dec_taken = '0;
        dec_acc = '0;
        dec_str_left = '0;
        dec_cnt_pending = 1'b0;
        dec_discard = 1'b0;
    endtask

    task automatic begin_payload(input phase_t p, input logic [4:0] s, input int n);
        dec_phase = p;
        dec_sub = s;
        dec_need = n[3:0];
        dec_taken = '0;
        dec_acc = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic l);
        logic [2:0]  kind;
        logic [4:0]  sub;
        token_t      t;
        logic        emit;
        logic        bad;
        logic [63:0] v;
        logic [31:0] len;
        phase_t      ph;
        kind = b[2:0];
        sub = b[7:3];
        emit = 1'b0;
        bad = 1'b0;
        t = tok(TK_NIL, '0, 1'b0, ERR_NONE);
        if (dec_discard)
        begin
            if (l)
                clear_parse();
            return;
        end
        case (dec_phase)
            PH_IDLE:
            begin
                case (kind)
                    TAG_NIL:
                    begin
                        t = tok(TK_NIL, '0, 1'b0, ERR_NONE);
                        emit = 1'b1;
                    end
                    TAG_BOOL:
                    begin
                        t = tok(TK_BOOL, {63'd0, sub != 0}, 1'b0, ERR_NONE);
                        emit = 1'b1;
                    end
                    TAG_NUMBER:
                    begin
                        if (sub == 0)
                        begin
                            t = tok(TK_INT, '0, 1'b0, ERR_NONE);
                            emit = 1'b1;
                        end
                        else if (sub == SUB_NUM_REAL)
                            begin_payload(PH_REAL, sub, 8);
                        else if (int_bytes(sub) != 0)
                            begin_payload(PH_INT, sub, int_bytes(sub));
                        else
                        begin
                            t = tok(TK_ERR, '0, 1'b0, ERR_INT_WIDTH);
                            emit = 1'b1;
                            bad = 1'b1;
                        end
                    end
                    TAG_PTR:
                        begin_payload(PH_PTR, sub, (ptr_cfg == PTR_BYTES_NARROW) ? 4 : 8);
                    TAG_SSTR:
                    begin
                        t = tok(TK_SSTART, {59'd0, sub}, 1'b0, ERR_NONE);
                        emit = 1'b1;
                        if (sub != 0)
                        begin
                            dec_str_left = {27'd0, sub};
                            dec_phase = PH_STR;
                        end
                    end
                    TAG_LSTR:
                    begin
                        if (sub >= 2 && sub <= 4)
                            begin_payload(PH_LEN, sub, int_bytes(sub));
                        else
                        begin
                            t = tok(TK_ERR, '0, 1'b0, ERR_LEN_WIDTH);
                            emit = 1'b1;
                            bad = 1'b1;
                        end
                    end
                    TAG_TABLE:
                    begin
                        if (sub == SUB_COUNT_ESCAPE)
                        begin
                            dec_phase = PH_CNTTAG;
                            dec_cnt_pending = 1'b1;
                        end
                        else
                        begin
                            t = tok(TK_TABLE, {59'd0, sub}, 1'b0, ERR_NONE);
                            emit = 1'b1;
                        end
                    end
                    default:
                        ;
                endcase
            end
            PH_CNTTAG:
            begin
                if (sub == 0)
                begin
                    t = tok(TK_TABLE, '0, 1'b0, ERR_NONE);
                    emit = 1'b1;
                    dec_phase = PH_IDLE;
                    dec_cnt_pending = 1'b0;
                end
                else if (int_bytes(sub) != 0)
                    begin_payload(PH_INT, sub, int_bytes(sub));
                else
                begin
                    t = tok(TK_ERR, '0, 1'b0, ERR_INT_WIDTH);
                    emit = 1'b1;
                    bad = 1'b1;
                    dec_phase = PH_IDLE;
                    dec_cnt_pending = 1'b0;
                end
            end
            PH_STR:
            begin
                dec_str_left = dec_str_left - 32'd1;
                t = tok(TK_SBYTE, {56'd0, b}, dec_str_left == 0, ERR_NONE);
                emit = 1'b1;
                if (dec_str_left == 0)
                    dec_phase = PH_IDLE;
            end
            default:
            begin
                dec_acc = dec_acc | ({56'd0, b} << (8 * dec_taken[2:0]));
                dec_taken = dec_taken + 4'd1;
                if (dec_taken >= dec_need)
                begin
                    v = dec_acc;
                    ph = dec_phase;
                    dec_phase = PH_IDLE;
                    emit = 1'b1;
                    if (ph == PH_INT)
                    begin
                        t = tok(dec_cnt_pending ? TK_TABLE : TK_INT, sized_int(dec_sub, v),
                                1'b0, ERR_NONE);
                        dec_cnt_pending = 1'b0;
                    end
                    else if (ph == PH_REAL)
                        t = tok(TK_REAL, v, 1'b0, ERR_NONE);
                    else if (ph == PH_PTR)
                    begin
                        if (dec_need == 4)
                            v = {32'd0, v[31:0]};
                        t = tok(TK_PTR, v, 1'b0, ERR_NONE);
                    end
                    else
                    begin
                        len = 32'(sized_int(dec_sub, v));
                        t = tok(TK_SSTART, {32'd0, len}, 1'b0, ERR_NONE);
                        if (len != 0)
                        begin
                            dec_str_left = len;
                            dec_phase = PH_STR;
                        end
                    end
                end
            end
        endcase
        if (l)
        begin
            if (dec_phase != PH_IDLE)
            begin
                t = tok(TK_ERR, '0, 1'b0, ERR_TRUNC);
                emit = 1'b1;
            end
            clear_parse();
        end
        else if (bad)
            dec_discard = 1'b1;
        if (emit)
            tokens_due.push_back(t);
    endtask

    task automatic check_token();
        token_t want;
        if (tokens_due.size() == 0)
        begin
            $error("unexpected token: token_kind %0d token_value %h",
                   m_axis_tuser[3:0], m_axis_tdata);
            mismatches++;
            return;
        end
        want = tokens_due.pop_front();
        if (m_axis_tuser[3:0] !== want.kind)
        begin
            $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser[3:0]);
            mismatches++;
        end
        if (m_axis_tdata !== want.value)
        begin
            $error("token_value: expected %h, actual %h", want.value, m_axis_tdata);
            mismatches++;
        end
        if (m_axis_tlast !== want.str_end)
        begin
            $error("string_end: expected %0b, actual %0b", want.str_end, m_axis_tlast);
            mismatches++;
        end
        if (m_axis_tuser[5:4] !== want.err)
        begin
            $error("error_code: expected %0d, actual %0d", want.err, m_axis_tuser[5:4]);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            ptr_cfg = cfg_data;
        if (s_axis_tvalid && s_axis_tready)
            predict_byte(s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready)
            check_token();
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin : token_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold != 0)
            begin
                stall = sink_hold;
                sink_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        items_sent += frame_bytes.size();
        frame_bytes.delete();
    endtask

    // quiet the input and let every outstanding token drain
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_pointer_bytes(input logic [3:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        ptr_setting = v;
    endtask

    task automatic add_bytes(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_value();
        int         sel;
        logic [4:0] s;
        int         w;
        int         n;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            frame_bytes.push_back(mk_tag(5'($urandom_range(0, 31)), TAG_NIL));
        else if (sel < 16)
            frame_bytes.push_back(mk_tag(5'($urandom_range(0, 31)), TAG_BOOL));
        else if (sel < 36)
        begin
            s = 5'($urandom_range(0, 5));
            frame_bytes.push_back(mk_tag(s, TAG_NUMBER));
            add_bytes(s == SUB_NUM_REAL ? 8 : int_bytes(s));
        end
        else if (sel < 44)
        begin
            frame_bytes.push_back(mk_tag(5'($urandom_range(0, 31)), TAG_PTR));
            add_bytes(ptr_setting == PTR_BYTES_NARROW ? 4 : 8);
        end
        else if (sel < 56)
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
            frame_bytes.push_back(mk_tag(5'(n), TAG_SSTR));
            add_bytes(n);
        end
        else if (sel < 66)
        begin
            s = 5'($urandom_range(2, 4));
            w = int_bytes(s);
            frame_bytes.push_back(mk_tag(s, TAG_LSTR));
            if ($urandom_range(0, 7) == 0)
                add_bytes(w);
            else
            begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < w; i++)
                    frame_bytes.push_back(8'((n >> (8 * i)) & 255));
                add_bytes(n);
            end
        end
        else if (sel < 78)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                s = 5'($urandom_range(0, 4));
                frame_bytes.push_back(mk_tag(SUB_COUNT_ESCAPE, TAG_TABLE));
                frame_bytes.push_back(mk_tag(s, 3'($urandom_range(0, 7))));
                add_bytes(int_bytes(s));
            end
            else
                frame_bytes.push_back(mk_tag(5'($urandom_range(0, 30)), TAG_TABLE));
        end
        else if (sel < 84)
            frame_bytes.push_back(mk_tag(5'($urandom_range(0, 31)), TAG_SKIP));
        else if (sel < 90)
        begin
            case ($urandom_range(0, 2))
                0:
                    frame_bytes.push_back(mk_tag(5'($urandom_range(6, 31)), TAG_NUMBER));
                1:
                begin
                    s = 5'($urandom_range(0, 28));
                    frame_bytes.push_back(mk_tag((s < 5'd2) ? s : s + 5'd3, TAG_LSTR));
                end
                default:
                begin
                    frame_bytes.push_back(mk_tag(SUB_COUNT_ESCAPE, TAG_TABLE));
                    frame_bytes.push_back(mk_tag(5'($urandom_range(5, 31)),
                                                 3'($urandom_range(0, 7))));
                end
            endcase
        end
        else
            add_bytes(1);
    endtask

    task automatic add_frame();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) add_value();
        if ($urandom_range(0, 4) == 0)
            frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
    endtask

    task automatic test_basic_tokens();
        frame_bytes = '{8'h00, 8'h01, 8'hF9, 8'h02, 8'h22, 8'hFF, 8'h1A, 8'hFF, 8'hFF,
                        8'h12, 8'h00, 8'h00, 8'h00, 8'h80, 8'h04, 8'h0C, 8'h41, 8'h36,
                        8'hFE, 8'h1F, 8'h34, 8'h12, 8'h07, 8'h25, 8'h01, 8'h5A};
        send_frame();
    endtask

    task automatic test_error_tokens();
        // bad integer width, then the rest of the buffer is dropped
        frame_bytes = '{8'h32, 8'h55, 8'hAA};
        send_frame();
        // bad length width on the final byte
        frame_bytes = '{8'h0D};
        send_frame();
        // bad count escape width
        frame_bytes = '{8'hFE, 8'h2A};
        send_frame();
        // payload cut short
        frame_bytes = '{8'h0A, 8'h01};
        send_frame();
        // string byte cut short
        frame_bytes = '{8'h14, 8'h41};
        send_frame();
    endtask

    task automatic test_pointer_width();
        settle();
        set_pointer_bytes(PTR_BYTES_NARROW);
        frame_bytes = '{8'h0B, 8'h78, 8'h56, 8'h34, 8'hF2};
        send_frame();
        settle();
        set_pointer_bytes(4'd15);
        frame_bytes = '{8'hFB, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
        send_frame();
    endtask

    task automatic test_random_buffers();
        logic [3:0] settings [7];
        int goal;
        settings = '{4'd8, 4'd4, 4'd0, 4'd15, 4'd4, 4'd5, 4'd8};
        for (int p = 0; p < 7; p++)
        begin
            settle();
            set_pointer_bytes(settings[p]);
            idle_on = (p != 2);
            goal = items_sent + 160;
            while (items_sent < goal)
            begin
                add_frame();
                send_frame();
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int goal;
        settle();
        idle_on = 1'b0;
        sink_hold = 300;
        goal = items_sent + 80;
        while (items_sent < goal)
        begin
            add_frame();
            send_frame();
        end
        settle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        idle_on = 1'b1;
        sink_hold = 0;
        mismatches = 0;
        items_sent = 0;
        ptr_setting = PTR_BYTES_RESET;
        ptr_cfg = PTR_BYTES_RESET;
        clear_parse();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_tokens();
        test_error_tokens();
        test_pointer_width();
        test_random_buffers();
        test_output_backpressure();
        settle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
